// ===== src/modular_inverse_macros.svh =====
// Assertion macros for the modular inverse block.
// Needs nothing else; included by the files that carry assertions.
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mi_pkg.sv =====
// Shared types, widths and codes of the modular inverse block.
// No dependencies.
package mi_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_NOT_INVERTIBLE = 2'd1;
    localparam logic [1:0] ST_BAD_MODULUS    = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] operand_value;
        logic [FIELD_W-1:0] modulus;
    } mi_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic [1:0]         status;
    } mi_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REDUCE,
        S_TEST,
        S_DIVIDE,
        S_FIX,
        S_DONE
    } mi_state_t;

    typedef struct packed {
        logic load;         // capture a new request
        logic div_start;    // launch the divider
        logic div_reduce;   // divider works on operand / modulus
        logic load_euclid;  // seed the remainder and coefficient pairs
        logic update;       // advance one Euclid step
        logic fix;          // fold the final coefficient below the modulus
        logic out_write;    // load the output register
    } mi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic p_small;
        logic r_zero;
        logic out_free;
    } mi_stat_t;

endpackage

// ===== src/mi_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle, MSB first.
// Depends on mi_pkg for the data width.
module mi_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mi_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [mi_pkg::DATA_WIDTH-1:0] divisor,
    output logic                          busy,
    output logic                          q_bit,
    output logic                          done,
    output logic [mi_pkg::DATA_WIDTH-1:0] remainder
);
    import mi_pkg::*;

    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    assign shifted = {rem_reg, dvd_reg[DATA_WIDTH-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DATA_WIDTH-2:0], ge};
            rem_next = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign q_bit     = ge;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/mi_datapath.sv =====
// Remainder and coefficient registers, divider, result logic and output register.
// Depends on mi_pkg and mi_divider.
module mi_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  mi_pkg::mi_cmd_t  cmd,
    output mi_pkg::mi_stat_t stat,
    input  mi_pkg::mi_in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mi_pkg::mi_out_t  m_data
);
    import mi_pkg::*;

    logic [DATA_WIDTH-1:0] a_reg, p_reg;
    logic [DATA_WIDTH-1:0] r_prev_reg, r_cur_reg;
    logic [DATA_WIDTH-1:0] c_prev_reg, c_cur_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic                  odd_reg;
    logic                  out_valid_reg, out_valid_next;
    mi_out_t               out_data_reg;

    logic                  div_busy, div_qbit, div_done;
    logic [DATA_WIDTH-1:0] div_rem;
    logic [DATA_WIDTH-1:0] inv_val;
    mi_out_t               result;

    mi_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (cmd.div_reduce ? a_reg : r_prev_reg),
        .divisor   (cmd.div_reduce ? p_reg : r_cur_reg),
        .busy      (div_busy),
        .q_bit     (div_qbit),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= DATA_WIDTH'(s_data.operand_value);
            p_reg <= DATA_WIDTH'(s_data.modulus);
        end
        // Build q * c_cur from the quotient bits as the divider emits them
        if (cmd.div_start) begin
            acc_reg <= '0;
        end else if (div_busy) begin
            acc_reg <= {acc_reg[DATA_WIDTH-2:0], 1'b0} + (div_qbit ? c_cur_reg : '0);
        end
        if (cmd.load_euclid) begin
            r_prev_reg <= p_reg;
            r_cur_reg  <= div_rem;
            c_prev_reg <= '0;
            c_cur_reg  <= DATA_WIDTH'(1);
            odd_reg    <= 1'b0;
        end else if (cmd.update) begin
            r_prev_reg <= r_cur_reg;
            r_cur_reg  <= div_rem;
            c_prev_reg <= c_cur_reg;
            c_cur_reg  <= c_prev_reg + acc_reg;
            odd_reg    <= ~odd_reg;
        end else if (cmd.fix) begin
            if (c_prev_reg >= p_reg) begin
                c_prev_reg <= c_prev_reg - p_reg;
            end
        end
    end

    // Final coefficient is positive after an odd step count, negative otherwise
    assign inv_val = odd_reg ? c_prev_reg :
                     (c_prev_reg == '0) ? '0 : p_reg - c_prev_reg;

    always_comb begin
        priority if (stat.p_small) begin
            result.status  = ST_BAD_MODULUS;
            result.inverse = '0;
        end else if (r_prev_reg != DATA_WIDTH'(1)) begin
            result.status  = ST_NOT_INVERTIBLE;
            result.inverse = '0;
        end else begin
            result.status  = ST_OK;
            result.inverse = FIELD_W'(inv_val);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_write) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.out_write) begin
            out_data_reg <= result;
        end
    end

    assign stat.div_done = div_done;
    assign stat.p_small  = p_reg < DATA_WIDTH'(2);
    assign stat.r_zero   = r_cur_reg == '0;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/mi_ctrl.sv =====
// Sequencer for the modular inverse: reduce, Euclid steps, fix-up, result.
// Depends on mi_pkg.
module mi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mi_pkg::mi_stat_t stat,
    output mi_pkg::mi_cmd_t  cmd
);
    import mi_pkg::*;

    mi_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_CHECK;
            S_CHECK:  state_next = stat.p_small ? S_DONE : S_REDUCE;
            S_REDUCE: if (stat.div_done) state_next = S_TEST;
            S_TEST:   state_next = stat.r_zero ? S_FIX : S_DIVIDE;
            S_DIVIDE: if (stat.div_done) state_next = S_TEST;
            S_FIX:    state_next = S_DONE;
            S_DONE:   if (stat.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_CHECK: begin
                cmd.div_reduce = 1'b1;
                cmd.div_start  = !stat.p_small;
            end
            S_REDUCE: begin
                cmd.div_reduce  = 1'b1;
                cmd.load_euclid = stat.div_done;
            end
            S_TEST:   cmd.div_start = !stat.r_zero;
            S_DIVIDE: cmd.update    = stat.div_done;
            S_FIX:    cmd.fix       = 1'b1;
            S_DONE:   cmd.out_write = stat.out_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/modular_inverse.sv =====
// Top level of the modular inverse (extended Euclid) block.
// Depends on mi_pkg, mi_ctrl, mi_datapath and modular_inverse_macros.svh.
//
//   channel | ports                      | payload
//   --------+----------------------------+---------------------------
//   request | s_valid, s_ready, s_data   | operand_value, modulus
//   result  | m_valid, m_ready, m_data   | inverse, status
//
// One request at a time. Each Euclid step runs one full division on the
// bit-per-cycle divider, so the time a request takes grows with its step count.
// A modulus below two is answered without starting the divider.
// Reset is synchronous, active low. A waiting result in the output register does
// not block the next request; only a second finished result stalls until taken.
`include "modular_inverse_macros.svh"

module modular_inverse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mi_pkg::mi_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mi_pkg::mi_out_t m_data
);
    import mi_pkg::*;

    mi_cmd_t  cmd;
    mi_stat_t stat;

    mi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mi_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `MI_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `MI_ASSERT_IMP(a_err_zero, aclk, aresetn, m_valid && m_data.status != ST_OK, m_data.inverse == '0, "error with nonzero inverse")
    `MI_ASSERT_IMP(a_ok_nonzero, aclk, aresetn, m_valid && m_data.status == ST_OK, m_data.inverse != '0, "zero inverse reported ok")

endmodule
